[src/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication form: antecedent holds, consequent must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |-> (cons), msg)

// Next-cycle form: antecedent holds, consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `ASSERT_CLK(label, clk, rst, (ante) |=> (cons), msg)

`endif

[src/jsue_pkg.sv]
// Types and constants of the JSON UTF-8 string escaper.
// Used by the front, queue and back modules; depends on nothing.
`default_nettype none

package jsue_pkg;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;

   localparam logic [7:0] CHR_TAB       = 8'h09;
   localparam logic [7:0] CHR_LF        = 8'h0a;
   localparam logic [7:0] CHR_CR        = 8'h0d;
   localparam logic [7:0] CHR_SPACE     = 8'h20;
   localparam logic [7:0] CHR_QUOTE     = 8'h22;
   localparam logic [7:0] CHR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHR_DEL       = 8'h7f;

   localparam logic [7:0] MASK_CONT  = 8'hc0;
   localparam logic [7:0] CODE_CONT  = 8'h80;
   localparam logic [7:0] MASK_LEAD2 = 8'he0;
   localparam logic [7:0] CODE_LEAD2 = 8'hc0;
   localparam logic [7:0] MASK_LEAD3 = 8'hf0;
   localparam logic [7:0] CODE_LEAD3 = 8'he0;
   localparam logic [7:0] MASK_LEAD4 = 8'hf8;
   localparam logic [7:0] CODE_LEAD4 = 8'hf0;

   localparam logic [15:0] CAPACITY_RESET = 16'd256;

   // One queue entry: up to four bytes emitted back to back, or a summary.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            is_summary;
      logic [15:0]     count;
   } burst_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[src/json_utf8_string_escaper_unit.sv]
// JSON string escaper for UTF-8 text. One raw byte is taken per cycle while
// the four-entry burst queue has room; each input item turns into zero to
// four result bytes (escapes, whole multi-byte characters) or one summary,
// and the output side delivers one result per cycle while the result port
// is not stalled. Input stalls only when the queue is full. The capacity
// register may be written while the block is idle.
`default_nettype none

module json_utf8_string_escaper_unit
   import jsue_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_string,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_summary,
   output logic             rsp_run_last,
   output logic [15:0]      rsp_total_count,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   queue_status_type q_status;
   burst_type        push_entry;
   burst_type        head_entry;
   logic             push;
   logic             pop;

   assign req_stall = q_status.full;

   jsue_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   jsue_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   jsue_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_entry      (head_entry),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_summary  (rsp_is_summary),
      .rsp_run_last    (rsp_run_last),
      .rsp_total_count (rsp_total_count)
   );

endmodule

`default_nettype wire

[src/jsue_queue.sv]
// Short FIFO of bursts between the escaper front and the output sequencer.
// Depends on jsue_pkg.
`default_nettype none

module jsue_queue
   import jsue_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire burst_type  push_entry,
   input  wire logic       pop,
   output burst_type       head_entry,
   output queue_status_type status
);

   burst_type                 entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_entry   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

[src/jsue_front.sv]
// Escaper front: takes one input byte per cycle while the queue has room, tracks
// UTF-8 sequences, capacity and halt state, and pushes whole bursts. Depends on jsue_pkg.
`default_nettype none

module jsue_front
   import jsue_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_string,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire queue_status_type q_status,
   output logic             push,
   output burst_type        push_entry
);

   typedef enum logic [2:0] {
      CLS_ESCAPE,
      CLS_SPACE,
      CLS_DROP,
      CLS_PLAIN,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4
   } class_type;

   localparam logic [33:0] COUNT_MAX = (34'd1 << COUNT_BITS) - 34'd1;

   logic [15:0]           cap_ff, cap_in;
   logic [7:0]            held_ff [3];
   logic [2:0]            exp_ff, exp_in;
   logic [1:0]            col_ff, col_in;
   logic [COUNT_BITS-1:0] wc_ff, wc_in;
   logic                  halt_ff, halt_in;

   logic            hold_we;
   logic [1:0]      hold_idx;
   logic            commit;
   logic [2:0]      cand_len;
   logic [3:0][7:0] cand_bytes;
   logic [33:0]     sum;
   logic            fail;
   logic            take;
   class_type       cls;

   assign take = req_valid && !q_status.full;

   always_comb begin
      if (req_in_byte == CHR_QUOTE || req_in_byte == CHR_BACKSLASH) begin
         cls = CLS_ESCAPE;
      end else if (req_in_byte == CHR_LF || req_in_byte == CHR_CR ||
                   req_in_byte == CHR_TAB) begin
         cls = CLS_SPACE;
      end else if (req_in_byte < CHR_SPACE || req_in_byte == CHR_DEL) begin
         cls = CLS_DROP;
      end else if (!req_in_byte[7]) begin
         cls = CLS_PLAIN;
      end else if ((req_in_byte & MASK_LEAD2) == CODE_LEAD2) begin
         cls = CLS_LEAD2;
      end else if ((req_in_byte & MASK_LEAD3) == CODE_LEAD3) begin
         cls = CLS_LEAD3;
      end else if ((req_in_byte & MASK_LEAD4) == CODE_LEAD4) begin
         cls = CLS_LEAD4;
      end else begin
         cls = CLS_DROP;
      end
   end

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_comb begin
      exp_in     = exp_ff;
      col_in     = col_ff;
      wc_in      = wc_ff;
      halt_in    = halt_ff;
      hold_we    = 1'b0;
      hold_idx   = col_ff;
      commit     = 1'b0;
      cand_len   = '0;
      cand_bytes = '0;
      push       = 1'b0;
      push_entry = '0;
      sum        = '0;
      fail       = 1'b0;

      if (take && req_end_of_string) begin
         push                  = 1'b1;
         push_entry.is_summary = 1'b1;
         push_entry.count      = 16'(wc_ff);
         exp_in                = '0;
         col_in                = '0;
         wc_in                 = '0;
         halt_in               = 1'b0;
      end else if (take && !halt_ff) begin
         if (exp_ff != '0) begin
            if ((req_in_byte & MASK_CONT) != CODE_CONT) begin
               // broken sequence: drop held bytes and stop output
               exp_in  = '0;
               col_in  = '0;
               halt_in = 1'b1;
            end else if ({1'b0, col_ff} + 3'd1 < exp_ff) begin
               hold_we = 1'b1;
               col_in  = col_ff + 1'b1;
            end else begin
               commit   = 1'b1;
               cand_len = {1'b0, col_ff} + 3'd1;
               for (int k = 0; k < 3; k++) begin
                  cand_bytes[k] = (2'(k) < col_ff) ? held_ff[k] : req_in_byte;
               end
               cand_bytes[3] = req_in_byte;
               exp_in        = '0;
               col_in        = '0;
            end
         end else begin
            unique case (cls)
               CLS_ESCAPE: begin
                  commit        = 1'b1;
                  cand_len      = 3'd2;
                  cand_bytes[0] = CHR_BACKSLASH;
                  cand_bytes[1] = req_in_byte;
               end
               CLS_SPACE: begin
                  commit        = 1'b1;
                  cand_len      = 3'd1;
                  cand_bytes[0] = CHR_SPACE;
               end
               CLS_DROP: begin
                  commit = 1'b1;
               end
               CLS_PLAIN: begin
                  commit        = 1'b1;
                  cand_len      = 3'd1;
                  cand_bytes[0] = req_in_byte;
               end
               CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
                  hold_we  = 1'b1;
                  hold_idx = '0;
                  col_in   = 2'd1;
                  exp_in   = (cls == CLS_LEAD2) ? 3'd2 :
                             (cls == CLS_LEAD3) ? 3'd3 : 3'd4;
               end
               default: begin
                  commit = 1'b1;
               end
            endcase
         end

         if (commit) begin
            sum  = 34'(wc_ff) + 34'(cand_len);
            fail = (sum + 34'd1 > 34'(cap_ff)) || (sum > COUNT_MAX);
            if (fail) begin
               halt_in = 1'b1;
            end else begin
               wc_in = wc_ff + COUNT_BITS'(cand_len);
               if (cand_len != '0) begin
                  push                = 1'b1;
                  push_entry.bytes    = cand_bytes;
                  push_entry.last_idx = 2'(cand_len - 3'd1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAPACITY_RESET;
         exp_ff  <= '0;
         col_ff  <= '0;
         wc_ff   <= '0;
         halt_ff <= 1'b0;
      end else begin
         cap_ff  <= cap_in;
         exp_ff  <= exp_in;
         col_ff  <= col_in;
         wc_ff   <= wc_in;
         halt_ff <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (hold_we && hold_idx == 2'(k)) begin
            held_ff[k] <= req_in_byte;
         end
      end
   end

endmodule

`default_nettype wire

[src/jsue_back.sv]
// Output sequencer: walks the head burst of the queue one byte per result
// and pops it after its last byte. Depends on jsue_pkg.
`default_nettype none

module jsue_back
   import jsue_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire burst_type   head_entry,
   input  wire queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_is_summary,
   output logic             rsp_run_last,
   output logic [15:0]      rsp_total_count
);

   logic [1:0] offset_ff, offset_in;
   logic       fire;

   assign rsp_valid       = !q_status.empty;
   assign rsp_out_byte    = head_entry.bytes[offset_ff];
   assign rsp_is_summary  = head_entry.is_summary;
   assign rsp_run_last    = (offset_ff == head_entry.last_idx);
   assign rsp_total_count = head_entry.count;

   assign fire = rsp_valid && !rsp_stall;
   assign pop  = fire && rsp_run_last;

   always_comb begin
      offset_in = offset_ff;
      if (pop) begin
         offset_in = '0;
      end else if (fire) begin
         offset_in = offset_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

`default_nettype wire

[src/jsue_checker.sv]
// Port-level checks of the escaper's result channel, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module jsue_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_is_summary,
   input wire logic        rsp_run_last,
   input wire logic [15:0] rsp_total_count
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `ASSERT_IMPL(a_sum_last, clock, reset, rsp_valid && rsp_is_summary, rsp_run_last, "summary not last of its item")
   `ASSERT_IMPL(a_sum_byte, clock, reset, rsp_valid && rsp_is_summary, rsp_out_byte == 8'd0, "summary byte not zero")
   `ASSERT_IMPL(a_byte_cnt, clock, reset, rsp_valid && !rsp_is_summary, rsp_total_count == 16'd0, "count on byte result")

endmodule

bind json_utf8_string_escaper_unit jsue_checker u_jsue_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_is_summary  (rsp_is_summary),
   .rsp_run_last    (rsp_run_last),
   .rsp_total_count (rsp_total_count)
);

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for json_utf8_string_escaper_unit: feeds raw string bytes,
// predicts the escaped byte stream and the per-string summaries, checks each result.
// Depends on jsue_pkg and the escaper top level.
module tb;
   import jsue_pkg::*;

   localparam int IDLE_PCT        = 18;
   localparam int SETTLE_CYCLES   = 20;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int COUNT_LIMIT     = 65535;
   localparam int TOTAL_ITEMS     = 326;
   localparam int MAX_PRINTED     = 100;

   localparam logic [7:0] DIRECTED_BYTES [19] = '{
      8'h41, CHR_QUOTE, CHR_BACKSLASH, CHR_LF, CHR_CR, CHR_TAB, 8'h00, CHR_DEL,
      8'hff, CODE_CONT, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98, 8'h80
   };

   typedef struct packed {
      logic [7:0] raw;
      logic       eos;
   } raw_item_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        is_summary;
      logic        run_last;
      logic [15:0] total_count;
   } escaped_type;

   typedef enum int {
      CH_PRINTABLE, CH_ESCAPED, CH_WHITESPACE, CH_CONTROL, CH_MULTIBYTE, CH_NOISE, CH_BROKEN
   } char_kind_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte       = 8'h00;
   logic        req_end_of_string = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_summary;
   logic        rsp_run_last;
   logic [15:0] rsp_total_count;
   logic        csr_wr_en         = 1'b0;
   logic [15:0] csr_wr_data       = 16'h0000;

   // predicted state of the escaper
   logic [15:0]  cap_model = CAPACITY_RESET;
   logic [7:0]   seq_held [3];
   logic [2:0]   seq_len   = 3'd0;
   logic [1:0]   seq_got   = 2'd0;
   int unsigned  emitted   = 0;
   logic         halted    = 1'b0;

   raw_item_type raw_pending [$];
   escaped_type  escaped_due [$];
   raw_item_type drive_item;
   escaped_type  seen, want;

   bit calm = 1'b0, hold_off_go = 1'b0, hold_off_used = 1'b0;
   int hold_left = 0;
   int items_queued = 0, strings_queued = 0, items_taken = 0;
   int results_checked = 0, mismatch_count = 0, settings_used = 1;

   json_utf8_string_escaper_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_is_summary    (rsp_is_summary),
      .rsp_run_last      (rsp_run_last),
      .rsp_total_count   (rsp_total_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < MAX_PRINTED) $display("[%0t] %s", $time, what);
      mismatch_count++;
   endtask

   // Accept a character of n output bytes only if it still leaves room for the terminator.
   task automatic emit_burst(input logic [3:0][7:0] burst, input int n);
      if (emitted + n + 1 > cap_model || emitted + n > COUNT_LIMIT) begin
         halted = 1'b1;
      end else begin
         for (int k = 0; k < n; k++)
            escaped_due.push_back(escaped_type'{out_byte: burst[k], is_summary: 1'b0,
                                                run_last: (k == n - 1), total_count: 16'd0});
         emitted += n;
      end
   endtask

   task automatic predict_escape(input logic [7:0] b, input logic eos);
      logic [3:0][7:0] burst;
      logic [2:0]      lead_len;
      int              n;
      burst    = '0;
      lead_len = ((b & MASK_LEAD2) == CODE_LEAD2) ? 3'd2 :
                 ((b & MASK_LEAD3) == CODE_LEAD3) ? 3'd3 :
                 ((b & MASK_LEAD4) == CODE_LEAD4) ? 3'd4 : 3'd0;
      if (eos) begin
         escaped_due.push_back(escaped_type'{out_byte: 8'h00, is_summary: 1'b1, run_last: 1'b1,
                                             total_count: emitted[15:0]});
         seq_held = '{default: 8'h00};
         seq_len  = 3'd0;
         seq_got  = 2'd0;
         emitted  = 0;
         halted   = 1'b0;
      end else if (!halted) begin
         if (seq_len != 3'd0) begin
            if ((b & MASK_CONT) != CODE_CONT) begin
               // drop the open character and the offending byte, then stop output
               seq_len = 3'd0;
               seq_got = 2'd0;
               halted  = 1'b1;
            end else if (seq_got + 3'd1 < seq_len) begin
               seq_held[seq_got] = b;
               seq_got++;
            end else begin
               for (int k = 0; k < int'(seq_got); k++) burst[k] = seq_held[k];
               burst[seq_got] = b;
               n       = int'(seq_got) + 1;
               seq_len = 3'd0;
               seq_got = 2'd0;
               emit_burst(burst, n);
            end
         end else if (b == CHR_QUOTE || b == CHR_BACKSLASH) begin
            burst[0] = CHR_BACKSLASH;
            burst[1] = b;
            emit_burst(burst, 2);
         end else if (b == CHR_LF || b == CHR_CR || b == CHR_TAB) begin
            burst[0] = CHR_SPACE;
            emit_burst(burst, 1);
         end else if (b < CHR_SPACE || b == CHR_DEL) begin
            emit_burst(burst, 0);
         end else if (!b[7]) begin
            burst[0] = b;
            emit_burst(burst, 1);
         end else if (lead_len != 3'd0) begin
            seq_len     = lead_len;
            seq_held[0] = b;
            seq_got     = 2'd1;
         end else begin
            // stray continuation or invalid lead byte still costs a capacity check
            emit_burst(burst, 0);
         end
      end
   endtask

   function automatic logic [7:0] lead_byte(input int len);
      logic [7:0] r;
      r = 8'($urandom);
      case (len)
         2: return CODE_LEAD2 | (r & ~MASK_LEAD2);
         3: return CODE_LEAD3 | (r & ~MASK_LEAD3);
         default: return CODE_LEAD4 | (r & ~MASK_LEAD4);
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      return CODE_CONT | (8'($urandom) & ~MASK_CONT);
   endfunction

   task automatic push_raw(input logic [7:0] b, input logic eos);
      raw_pending.push_back(raw_item_type'{raw: b, eos: eos});
      items_queued++;
      if (eos) strings_queued++;
   endtask

   // Mostly well-formed text with random content, a little noise and some broken characters.
   task automatic push_string(input int n_chars);
      int            r;
      int            len;
      logic [7:0]    b;
      char_kind_type kind;
      for (int c = 0; c < n_chars; c++) begin
         r = $urandom_range(99);
         kind = (r < 35) ? CH_PRINTABLE : (r < 47) ? CH_ESCAPED : (r < 57) ? CH_WHITESPACE :
                (r < 62) ? CH_CONTROL : (r < 90) ? CH_MULTIBYTE : (r < 95) ? CH_NOISE :
                CH_BROKEN;
         len = $urandom_range(2, 4);
         case (kind)
            CH_PRINTABLE: push_raw(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
            CH_ESCAPED: push_raw($urandom_range(1) ? CHR_QUOTE : CHR_BACKSLASH, 1'b0);
            CH_WHITESPACE: begin
               r = $urandom_range(2);
               push_raw((r == 0) ? CHR_LF : (r == 1) ? CHR_CR : CHR_TAB, 1'b0);
            end
            CH_CONTROL: push_raw($urandom_range(3) == 0 ? CHR_DEL :
                                 8'($urandom_range(0, 8'h1f)), 1'b0);
            CH_MULTIBYTE: begin
               push_raw(lead_byte(len), 1'b0);
               repeat (len - 1) push_raw(cont_byte(), 1'b0);
            end
            CH_NOISE: push_raw(8'($urandom), 1'b0);
            default: begin
               // short character; without the breaking byte it may run into the end
               push_raw(lead_byte(len), 1'b0);
               repeat ($urandom_range(0, len - 2)) push_raw(cont_byte(), 1'b0);
               if ($urandom_range(1)) begin
                  b = 8'($urandom);
                  if ((b & MASK_CONT) == CODE_CONT) b = b ^ 8'h40;
                  push_raw(b, 1'b0);
               end
            end
         endcase
      end
      push_raw(8'($urandom), 1'b1);
   endtask

   task automatic write_capacity(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_model = value;
      settings_used++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (raw_pending.size() != 0 || req_valid || escaped_due.size() != 0)
         @(negedge clock);
      // an open character can still be held inside with nothing expected
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Sender: hold a stalled item, otherwise offer the next pending one unless idling.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_escape(req_in_byte, req_end_of_string);
            items_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (raw_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               drive_item = raw_pending.pop_front();
               req_valid         <= 1'b1;
               req_in_byte       <= drive_item.raw;
               req_end_of_string <= drive_item.eos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_out_byte, rsp_is_summary, rsp_run_last, rsp_total_count};
            if (escaped_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result byte %h summary %b count %0d",
                                         seen.out_byte, seen.is_summary, seen.total_count));
            end else begin
               want = escaped_due.pop_front();
               if (seen !== want)
                  report_mismatch($sformatf(
                     "result %0d: got byte %h sum %b last %b count %0d, want %h %b %b %0d",
                     results_checked, seen.out_byte, seen.is_summary, seen.run_last,
                     seen.total_count, want.out_byte, want.is_summary, want.run_last,
                     want.total_count));
            end
            results_checked++;
         end
         if (hold_off_go && !hold_off_used) begin
            hold_left     = HOLD_OFF_CYCLES;
            hold_off_used = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed string at the reset capacity: every byte class at least once
      foreach (DIRECTED_BYTES[i]) push_raw(DIRECTED_BYTES[i], 1'b0);
      push_raw(8'($urandom), 1'b1);
      // broken character: the ASCII byte after it and the next one are both lost
      push_raw(8'he2, 1'b0);
      push_raw(8'h41, 1'b0);
      push_raw(8'h41, 1'b0);
      push_raw(8'hff, 1'b1);
      // character still open at the end of the string
      push_raw(8'hf0, 1'b0);
      push_raw(8'h9f, 1'b0);
      push_raw(8'h00, 1'b1);
      wait_drained();

      write_capacity(16'd0);
      repeat (3) push_string($urandom_range(1, 4));
      wait_drained();

      for (int s = 0; s < 3; s++) begin
         write_capacity((s == 0) ? 16'd1 : 16'($urandom_range(2, 8)));
         repeat (3) push_string($urandom_range(2, 6));
         wait_drained();
      end

      write_capacity(16'hffff);
      calm = 1'b1;
      repeat (8) push_string($urandom_range(4, 10));
      wait_drained();
      calm = 1'b0;

      // queue plenty of items, then starve the output so the block backs up
      write_capacity(16'($urandom_range(24, 80)));
      repeat (6) push_string($urandom_range(1, 12));
      hold_off_go = 1'b1;
      while (items_queued < 280) push_string($urandom_range(1, 12));
      wait_drained();

      write_capacity(CAPACITY_RESET);
      while (items_queued < TOTAL_ITEMS) push_string($urandom_range(1, 12));
      wait_drained();

      $display("Sent %0d items in %0d strings across %0d capacity settings;",
               items_taken, strings_queued, settings_used);
      $display("checked %0d results, including escapes, multi-byte and capacity cut-offs.",
               results_checked);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d results outstanding", escaped_due.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
+incdir+src
src/jsue_pkg.sv
src/jsue_queue.sv
src/jsue_front.sv
src/jsue_back.sv
src/json_utf8_string_escaper_unit.sv
src/jsue_checker.sv
test/tb.sv
